@@ rtl/core/fns_pkg.sv @@
// Shared types and constants for the FNV-1a numeric stat summarizer.
`default_nettype none

package fns_pkg;

   // One byte of stat text with its end-of-stream marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Summary given at the end of a stream.
   typedef struct packed {
      logic [63:0] signature;
      logic [31:0] additions_total;
      logic [31:0] deletions_total;
   } rsp_type;

   // Parse state of one numeric field.
   typedef enum logic [1:0] {
      FIELD_WAIT   = 2'd0,
      FIELD_DIGITS = 2'd1,
      FIELD_DONE   = 2'd2,
      FIELD_BAD    = 2'd3
   } field_status_type;

   localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;

   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Tabs counted per line saturate here; a line needs this many to be a record.
   localparam logic [1:0] TAB_LIMIT = 2'd2;

endpackage : fns_pkg

`default_nettype wire

@@ rtl/core/fnv1a_numstat_summarizer.sv @@
// Top level: FNV-1a hash and numeric stat totals over a byte stream.
// The last byte's request passes through the input register and then the output register,
// which offers the summary; a stalled result ahead can hold it in the input register.
// Throughput: one byte per cycle; the input stalls only when a finished result
// still waits in the output register and the next last byte is ready behind it.
// Reset (synchronous, active high) empties both registers and returns the hash
// to the offset basis and all parse state and totals to zero.
`default_nettype none

module fnv1a_numstat_summarizer #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire fns_pkg::req_type req,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output fns_pkg::rsp_type     rsp
);

   import fns_pkg::*;

   localparam int PROD_WIDTH = COUNT_WIDTH + 4;

   // Input register.
   logic             stage_valid_ff;
   req_type          stage_ff;
   logic             advance;
   logic             req_take;

   // Stream state.
   logic [63:0]            hash_ff, hash_in;
   logic [1:0]             tab_count_ff, tab_count_in;
   logic                   line_nonempty_ff, line_nonempty_in;
   logic                   halted_ff, halted_in;
   logic [COUNT_WIDTH-1:0] first_value_ff, first_value_in;
   field_status_type       first_status_ff, first_status_in;
   logic [COUNT_WIDTH-1:0] second_value_ff, second_value_in;
   field_status_type       second_status_ff, second_status_in;
   logic [COUNT_WIDTH-1:0] add_sum_ff, add_sum_in;
   logic [COUNT_WIDTH-1:0] del_sum_ff, del_sum_in;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Combinational working values.
   logic [7:0]             cur_byte;
   logic                   is_newline;
   logic                   is_digit;
   logic                   line_closes;
   logic [63:0]            hash_mix;
   logic [63:0]            hash_next;
   logic [COUNT_WIDTH-1:0] act_value;
   field_status_type       act_status;
   logic [PROD_WIDTH-1:0]  scaled;
   logic                   overflow;
   logic [COUNT_WIDTH-1:0] feed_value;
   field_status_type       feed_status;
   logic [1:0]             tab_post;
   logic                   nonempty_post;
   logic [COUNT_WIDTH-1:0] first_value_post, second_value_post;
   field_status_type       first_status_post, second_status_post;
   logic [COUNT_WIDTH-1:0] add_sum_next, del_sum_next;
   logic                   halted_next;
   logic                   fields_ok;

   // A byte leaves the input register unless its result would overwrite an unread one.
   assign advance   = stage_valid_ff && (!stage_ff.last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_take) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= req;
      end
   end

   // FNV-1a step: xor the byte in, then multiply by the prime 2^40 + 0x1B3.
   always_comb begin
      hash_mix  = hash_ff ^ {56'd0, cur_byte};
      hash_next = (hash_mix << 40) + (hash_mix << 8) + (hash_mix << 7)
                + (hash_mix << 5) + (hash_mix << 4) + (hash_mix << 1) + hash_mix;
   end

   // Feed the byte into whichever field the tab count selects.
   always_comb begin
      cur_byte    = stage_ff.data_byte;
      is_newline  = (cur_byte == CHAR_NEWLINE);
      is_digit    = cur_byte inside {[CHAR_ZERO:CHAR_NINE]};
      line_closes = is_newline || stage_ff.last_byte;

      if (tab_count_ff == 2'd0) begin
         act_value  = first_value_ff;
         act_status = first_status_ff;
      end else begin
         act_value  = second_value_ff;
         act_status = second_status_ff;
      end

      // value * 10 + digit; any bit above COUNT_WIDTH means the field overflowed.
      scaled = (PROD_WIDTH'(act_value) << 3) + (PROD_WIDTH'(act_value) << 1)
             + PROD_WIDTH'(cur_byte - CHAR_ZERO);
      overflow = |scaled[PROD_WIDTH-1:COUNT_WIDTH];

      feed_value  = act_value;
      feed_status = act_status;
      if (act_status == FIELD_WAIT || act_status == FIELD_DIGITS) begin
         if (!is_digit) begin
            feed_status = (act_status == FIELD_WAIT) ? FIELD_BAD : FIELD_DONE;
         end else if (overflow) begin
            feed_status = FIELD_BAD;
         end else begin
            feed_value  = scaled[COUNT_WIDTH-1:0];
            feed_status = FIELD_DIGITS;
         end
      end
   end

   // Line state after this byte, before any end-of-line handling.
   always_comb begin
      tab_post           = tab_count_ff;
      nonempty_post      = line_nonempty_ff;
      first_value_post   = first_value_ff;
      first_status_post  = first_status_ff;
      second_value_post  = second_value_ff;
      second_status_post = second_status_ff;
      if (!is_newline) begin
         nonempty_post = 1'b1;
         if (!halted_ff && tab_count_ff != TAB_LIMIT) begin
            if (tab_count_ff == 2'd0) begin
               first_value_post  = feed_value;
               first_status_post = feed_status;
            end else begin
               second_value_post  = feed_value;
               second_status_post = feed_status;
            end
            if (cur_byte == CHAR_TAB) begin
               tab_post = tab_count_ff + 2'd1;
            end
         end
      end
   end

   // Judge a finished line: halt on a short or empty line, else add valid fields.
   always_comb begin
      fields_ok = (first_status_post == FIELD_DIGITS || first_status_post == FIELD_DONE)
               && (second_status_post == FIELD_DIGITS || second_status_post == FIELD_DONE);
      add_sum_next = add_sum_ff;
      del_sum_next = del_sum_ff;
      halted_next  = halted_ff;
      if (line_closes && !halted_ff) begin
         if (!nonempty_post || tab_post != TAB_LIMIT) begin
            halted_next = 1'b1;
         end else if (fields_ok) begin
            add_sum_next = add_sum_ff + first_value_post;
            del_sum_next = del_sum_ff + second_value_post;
         end
      end
   end

   // Next state: lines clear at their end, and the whole stream clears at the last byte.
   always_comb begin
      hash_in          = hash_ff;
      tab_count_in     = tab_count_ff;
      line_nonempty_in = line_nonempty_ff;
      halted_in        = halted_ff;
      first_value_in   = first_value_ff;
      first_status_in  = first_status_ff;
      second_value_in  = second_value_ff;
      second_status_in = second_status_ff;
      add_sum_in       = add_sum_ff;
      del_sum_in       = del_sum_ff;
      if (advance) begin
         hash_in          = hash_next;
         tab_count_in     = tab_post;
         line_nonempty_in = nonempty_post;
         halted_in        = halted_next;
         first_value_in   = first_value_post;
         first_status_in  = first_status_post;
         second_value_in  = second_value_post;
         second_status_in = second_status_post;
         add_sum_in       = add_sum_next;
         del_sum_in       = del_sum_next;
         if (line_closes) begin
            tab_count_in     = '0;
            line_nonempty_in = 1'b0;
            first_value_in   = '0;
            first_status_in  = FIELD_WAIT;
            second_value_in  = '0;
            second_status_in = FIELD_WAIT;
         end
         if (stage_ff.last_byte) begin
            hash_in    = FNV_OFFSET_BASIS;
            halted_in  = 1'b0;
            add_sum_in = '0;
            del_sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff          <= FNV_OFFSET_BASIS;
         tab_count_ff     <= '0;
         line_nonempty_ff <= 1'b0;
         halted_ff        <= 1'b0;
         first_value_ff   <= '0;
         first_status_ff  <= FIELD_WAIT;
         second_value_ff  <= '0;
         second_status_ff <= FIELD_WAIT;
         add_sum_ff       <= '0;
         del_sum_ff       <= '0;
      end else begin
         hash_ff          <= hash_in;
         tab_count_ff     <= tab_count_in;
         line_nonempty_ff <= line_nonempty_in;
         halted_ff        <= halted_in;
         first_value_ff   <= first_value_in;
         first_status_ff  <= first_status_in;
         second_value_ff  <= second_value_in;
         second_status_ff <= second_status_in;
         add_sum_ff       <= add_sum_in;
         del_sum_ff       <= del_sum_in;
      end
   end

   // Output register: loads the summary at the last byte and holds it while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (advance && stage_ff.last_byte) begin
         rsp_valid_in           = 1'b1;
         rsp_in.signature       = hash_next;
         rsp_in.additions_total = 32'(add_sum_next);
         rsp_in.deletions_total = 32'(del_sum_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule : fnv1a_numstat_summarizer

`default_nettype wire

@@ rtl/core/fns_checker.sv @@
// Port-level assertions for the summarizer, bound to its top level.
`default_nettype none

module fns_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire fns_pkg::req_type req,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire fns_pkg::rsp_type rsp
);

   import fns_pkg::*;

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp))
      else $error("result changed while stalled");

   // The input only stalls behind a result that is itself stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   // A last byte that is taken and meets no result stall in the input register gives its summary.
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req.last_byte) ##1 !rsp_stall |=> rsp_valid)
      else $error("no summary after the last byte");

endmodule : fns_checker

bind fnv1a_numstat_summarizer fns_checker u_fns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire
